// ===== src/pdm_pkg.sv =====
// ============================================================================
// pdm_pkg
// Shared types and fixed field widths of the pairwise distance matrix core.
// ============================================================================
package pdm_pkg;

    // fixed field widths of the stream words
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DIST_W  = 25;
    localparam int OUT_DW  = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    // command codes carried in the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ROW  = 1'b1;

    // sideband that travels with each word down the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic             last;
        logic             err;
    } t_tag;

endpackage

// ===== src/pdm_row_seq.sv =====
// ============================================================================
// pdm_row_seq
// Point memory and row sequencer: stores loaded points and reads one row
// point followed by every column point of the row.
// ============================================================================
module pdm_row_seq #(
    parameter int MAX_CITIES  = 64,
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [pdm_pkg::IDX_W-1:0]     i_idx,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic [pdm_pkg::CNT_W-1:0]     i_n_eff,
    output logic                          o_vld,
    output pdm_pkg::t_tag                 o_tag,
    output logic signed [COORD_WIDTH-1:0] o_row_x,
    output logic signed [COORD_WIDTH-1:0] o_row_y,
    output logic signed [COORD_WIDTH-1:0] o_col_x,
    output logic signed [COORD_WIDTH-1:0] o_col_y
);

    localparam int AW = $clog2(MAX_CITIES);
    localparam int CW = COORD_WIDTH;
    localparam logic [pdm_pkg::CNT_W-1:0] MAX_N = pdm_pkg::CNT_W'(MAX_CITIES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_ROW   = 2'd2;

    logic [2*CW-1:0] mem [MAX_CITIES];
    logic [2*CW-1:0] r_rd_data;
    logic [2*CW-1:0] r_row;

    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_row_idx;
    logic            r_latch, n_latch;
    logic            r_vld, n_vld;
    pdm_pkg::t_tag   r_tag, n_tag;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            accept;
    logic            is_row;
    logic            row_bad;
    logic            idx_ok;
    logic            col_last;

    assign o_ready  = (r_state == ST_IDLE) && i_adv;
    assign accept   = i_valid && o_ready;
    assign is_row   = (i_cmd == pdm_pkg::CMD_ROW);
    assign row_bad  = ({1'b0, i_idx} >= i_n_eff);
    assign idx_ok   = ({1'b0, i_idx} < MAX_N);
    assign col_last = (pdm_pkg::CNT_W'(r_j) == (i_n_eff - 7'd1));

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_latch = 1'b0;
        n_vld   = 1'b0;
        n_tag   = '0;
        rd_en   = 1'b0;
        rd_addr = r_j;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_row) begin
                    if (row_bad) begin
                        // bad row index: one error word, nothing read
                        n_vld      = 1'b1;
                        n_tag.last = 1'b1;
                        n_tag.err  = 1'b1;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (i_adv) begin
                    rd_en   = 1'b1;
                    rd_addr = r_row_idx;
                    n_latch = 1'b1;
                    n_j     = '0;
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (i_adv) begin
                    rd_en      = 1'b1;
                    n_vld      = 1'b1;
                    n_tag.col  = pdm_pkg::IDX_W'(r_j);
                    n_tag.last = col_last;
                    if (col_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
            r_latch <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_latch <= n_latch;
            if (i_adv) begin
                r_vld <= n_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag <= n_tag;
        end
        if (accept) begin
            r_row_idx <= i_idx[AW-1:0];
        end
        // row point is latched from the read data in the cycle after the fetch read
        if (r_latch) begin
            r_row <= r_rd_data;
        end
    end

    // point memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (accept && !is_row && idx_ok) begin
            mem[i_idx[AW-1:0]] <= {i_y, i_x};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_vld   = r_vld;
    assign o_tag   = r_tag;
    assign o_col_x = r_rd_data[CW-1:0];
    assign o_col_y = r_rd_data[2*CW-1:CW];
    assign o_row_x = r_row[CW-1:0];
    assign o_row_y = r_row[2*CW-1:CW];

    property p_no_read_in_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_IDLE) |-> !rd_en;
    endproperty
    a_no_read_in_idle: assert property (p_no_read_in_idle)
        else $error("point memory read while sequencer idle");

    property p_fetch_then_latch;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_FETCH) && i_adv |=> r_latch && (r_state == ST_ROW) && !r_vld;
    endproperty
    a_fetch_then_latch: assert property (p_fetch_then_latch)
        else $error("row point not latched after fetch");

    property p_row_bounds;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_ROW) |-> (pdm_pkg::CNT_W'(r_j) < i_n_eff);
    endproperty
    a_row_bounds: assert property (p_row_bounds)
        else $error("column counter beyond city count");

endmodule

// ===== src/pdm_dist_calc.sv =====
// ============================================================================
// pdm_dist_calc
// Three stage datapath: absolute coordinate differences, squares, and the
// sum of squares that feeds the square root.
// ============================================================================
module pdm_dist_calc #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_vld,
    input  pdm_pkg::t_tag                 i_tag,
    input  logic signed [COORD_WIDTH-1:0] i_row_x,
    input  logic signed [COORD_WIDTH-1:0] i_row_y,
    input  logic signed [COORD_WIDTH-1:0] i_col_x,
    input  logic signed [COORD_WIDTH-1:0] i_col_y,
    output logic                          o_vld,
    output pdm_pkg::t_tag                 o_tag,
    output logic [2*COORD_WIDTH+1:0]      o_rad
);

    localparam int CW = COORD_WIDTH;
    localparam int S  = 2*CW + 2;

    logic [CW:0]     dx, dy, ndx, ndy;
    logic [CW-1:0]   ax, ay;
    logic [2*CW-1:0] sq_x, sq_y;

    logic [CW-1:0]   r_ax, r_ay;
    logic [2*CW-1:0] r_sx, r_sy;
    logic [S-1:0]    r_rad;
    logic [2:0]      r_vld;
    pdm_pkg::t_tag   r_tag [3];

    always_comb begin
        dx  = {i_row_x[CW-1], i_row_x} - {i_col_x[CW-1], i_col_x};
        dy  = {i_row_y[CW-1], i_row_y} - {i_col_y[CW-1], i_col_y};
        ndx = -dx;
        ndy = -dy;
        // magnitude of a difference of two signed values fits in CW bits
        ax  = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
        ay  = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
    end

    assign sq_x = r_ax * r_ax;
    assign sq_y = r_ay * r_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ax     <= ax;
            r_ay     <= ay;
            r_sx     <= sq_x;
            r_sy     <= sq_y;
            r_rad    <= S'(r_sx) + S'(r_sy);
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    assign o_vld = r_vld[2];
    assign o_tag = r_tag[2];
    // error words carry a zero radicand so their distance comes out zero
    assign o_rad = r_tag[2].err ? '0 : r_rad;

endmodule

// ===== src/pdm_sqrt_pipe.sv =====
// ============================================================================
// pdm_sqrt_pipe
// Pipelined floor square root, one root bit resolved per stage.
// ============================================================================
module pdm_sqrt_pipe #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  pdm_pkg::t_tag            i_tag,
    input  logic [2*COORD_WIDTH+1:0] i_rad,
    output logic                     o_vld,
    output pdm_pkg::t_tag            o_tag,
    output logic [COORD_WIDTH:0]     o_root
);

    localparam int R  = COORD_WIDTH + 1;
    localparam int S  = 2*R;
    localparam int RW = R + 2;

    logic [S-1:0]  r_rad [R-1];
    logic [RW-1:0] r_rem [R-1];
    logic [R-1:0]  r_q   [R];
    pdm_pkg::t_tag r_tag [R];
    logic [R-1:0]  r_vld;

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic [S-1:0]  rad_in;
        logic [RW-1:0] rem_in;
        logic [R-1:0]  q_in;
        pdm_pkg::t_tag tag_in;
        logic          vld_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rad_in = i_rad;
            assign rem_in = '0;
            assign q_in   = '0;
            assign tag_in = i_tag;
            assign vld_in = i_vld;
        end else begin : g_next
            assign rad_in = r_rad[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign tag_in = r_tag[k-1];
            assign vld_in = r_vld[k-1];
        end

        // bring down the next two radicand bits, try q*4+1
        assign rem_sh = {rem_in[RW-3:0], rad_in[S-1:S-2]};
        assign trial  = {q_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q[k]   <= {q_in[R-2:0], take};
                r_tag[k] <= tag_in;
            end
        end

        if (k < R-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rad[k] <= rad_in << 2;
                    r_rem[k] <= take ? (rem_sh - trial) : rem_sh;
                end
            end
        end
    end

    assign o_vld  = r_vld[R-1];
    assign o_tag  = r_tag[R-1];
    assign o_root = r_q[R-1];

endmodule

// ===== src/pairwise_distance_matrix_core.sv =====
// ============================================================================
// pairwise_distance_matrix_core
// All-pairs Euclidean distance rows over a stored set of fixed-point points.
// ============================================================================
// Usage:
//   input stream: tuser is the command (0 load, 1 row), tdata carries the
//   point index and the x/y coordinates. A load writes the point and gives no
//   word. A row command reads the row point, then every column 0 .. n-1 and
//   returns one distance word per column, tlast on the final one. A row index
//   at or above the city count gives one word with tuser (index error) and
//   tlast set and zero data.
//   output stream: tdata is the floor distance and column index.
//   city count is written through i_cfg_we / i_cfg_wdata while idle; values
//   above MAX_CITIES act as MAX_CITIES.
//   row reads: the sequencer has one memory read port and reads one column per
//   cycle while the receiver does not stall; it takes no new command until the
//   last column is read, while a load leaves it ready for the next command. The
//   root pipeline resolves one root bit per stage over COORD_WIDTH + 1 stages.
//   reset clears the control state and sets the city count to 64; stored
//   points are undefined until loaded. When the receiver stalls, the whole
//   pipeline holds and no new command is taken.
// ============================================================================
module pairwise_distance_matrix_core #(
    parameter int  MAX_CITIES  = 64,
    parameter int  COORD_WIDTH = 24,
    localparam int IN_DW       = ((pdm_pkg::IDX_W + 2*COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pdm_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [IN_DW-1:0]              i_s_tdata,   // point_index, x_coord, y_coord
    input  logic                          i_s_tuser,   // command
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pdm_pkg::OUT_DW-1:0]    o_m_tdata,   // distance_value, column_index
    output logic                          o_m_tlast,   // row_last
    output logic                          o_m_tuser    // index_error
);

    localparam int CW = COORD_WIDTH;
    localparam int R  = COORD_WIDTH + 1;
    localparam int IW = pdm_pkg::IDX_W;
    localparam int DW = pdm_pkg::DIST_W;
    localparam logic [pdm_pkg::CNT_W-1:0] MAX_N = pdm_pkg::CNT_W'(MAX_CITIES);

    logic [pdm_pkg::CNT_W-1:0] r_city_count;
    logic [pdm_pkg::CNT_W-1:0] n_eff;
    logic                      adv;

    logic                      seq_vld;
    pdm_pkg::t_tag             seq_tag;
    logic signed [CW-1:0]      row_x, row_y, col_x, col_y;

    logic                      calc_vld;
    pdm_pkg::t_tag             calc_tag;
    logic [2*CW+1:0]           calc_rad;

    logic                      sq_vld;
    pdm_pkg::t_tag             sq_tag;
    logic [R-1:0]              sq_root;
    logic [DW-1:0]             dist_sat;

    logic                      r_out_valid;
    logic [DW-1:0]             r_dist;
    pdm_pkg::t_tag             r_out_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= pdm_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            r_city_count <= i_cfg_wdata;
        end
    end

    assign n_eff = (r_city_count > MAX_N) ? MAX_N : r_city_count;

    // the whole pipeline moves when the output register can take a word
    assign adv = !r_out_valid || i_m_tready;

    pdm_row_seq #(
        .MAX_CITIES  (MAX_CITIES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cmd   (i_s_tuser),
        .i_idx   (i_s_tdata[IW-1:0]),
        .i_x     (i_s_tdata[IW+CW-1:IW]),
        .i_y     (i_s_tdata[IW+2*CW-1:IW+CW]),
        .i_n_eff (n_eff),
        .o_vld   (seq_vld),
        .o_tag   (seq_tag),
        .o_row_x (row_x),
        .o_row_y (row_y),
        .o_col_x (col_x),
        .o_col_y (col_y)
    );

    pdm_dist_calc #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (seq_vld),
        .i_tag   (seq_tag),
        .i_row_x (row_x),
        .i_row_y (row_y),
        .i_col_x (col_x),
        .i_col_y (col_y),
        .o_vld   (calc_vld),
        .o_tag   (calc_tag),
        .o_rad   (calc_rad)
    );

    pdm_sqrt_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (calc_vld),
        .i_tag   (calc_tag),
        .i_rad   (calc_rad),
        .o_vld   (sq_vld),
        .o_tag   (sq_tag),
        .o_root  (sq_root)
    );

    // clamp to the output field when the root can be wider than it
    if (R > DW) begin : g_sat
        assign dist_sat = (|sq_root[R-1:DW]) ? '1 : sq_root[DW-1:0];
    end else begin : g_nosat
        assign dist_sat = DW'(sq_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dist    <= dist_sat;
            r_out_tag <= sq_tag;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = pdm_pkg::OUT_DW'({r_out_tag.col, r_dist});
    assign o_m_tlast  = r_out_tag.last;
    assign o_m_tuser  = r_out_tag.err;

    property p_err_is_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_m_tvalid && o_m_tuser |-> o_m_tlast;
    endproperty
    a_err_is_last: assert property (p_err_is_last)
        else $error("error word without tlast");

    property p_err_zero_data;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_m_tvalid && o_m_tuser |-> (o_m_tdata == '0);
    endproperty
    a_err_zero_data: assert property (p_err_zero_data)
        else $error("error word carries nonzero data");

    property p_last_column;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_m_tvalid && o_m_tlast && !o_m_tuser |->
                ({1'b0, r_out_tag.col} == (n_eff - 7'd1));
    endproperty
    a_last_column: assert property (p_last_column)
        else $error("tlast not on the final column");

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb
// Stream-level check of the pairwise distance matrix core: point loads and
// distance rows are fed through the input stream and every returned word is
// checked against a predicted distance row, over several city counts and
// flow-control patterns.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W         = pdm_pkg::IDX_W;
    localparam int CNT_W         = pdm_pkg::CNT_W;
    localparam int DIST_W        = pdm_pkg::DIST_W;
    localparam int OUT_DW        = pdm_pkg::OUT_DW;
    localparam int N_SLOTS       = 64;
    localparam int CRD_W         = 24;
    localparam int IN_DW         = ((IDX_W + 2*CRD_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
    } t_point_cmd;

    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic              err;
    } t_dist_word;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [IN_DW-1:0]     i_s_tdata   = '0;   // point_index, x_coord, y_coord
    logic                 i_s_tuser   = 1'b0; // command
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_DW-1:0]    o_m_tdata;          // distance_value, column_index
    logic                 o_m_tlast;          // row_last
    logic                 o_m_tuser;          // index_error

    // predictor state
    logic signed [CRD_W-1:0] pt_x [N_SLOTS];
    logic signed [CRD_W-1:0] pt_y [N_SLOTS];
    logic [CNT_W-1:0]        cities_cfg = pdm_pkg::CNT_RESET;

    t_point_cmd pend_q[$];
    t_dist_word dist_due_q[$];

    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_go       = 1'b0;
    bit  hold_done     = 1'b0;
    bit  in_taken      = 1'b0;
    int  cycle_cnt     = 0;
    int  cmds_pushed   = 0;
    int  cmds_taken    = 0;
    int  loads_done    = 0;
    int  rows_done     = 0;
    int  words_seen    = 0;
    int  err_words     = 0;
    int  cfg_writes    = 0;
    int  fail_cnt      = 0;

    pairwise_distance_matrix_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // floor square root, one result bit per step from the top
    function automatic logic [DIST_W-1:0] floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = DIST_W - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r[DIST_W-1:0];
    endfunction

    // output check first, then predict the command taken at this edge
    always @(posedge i_clk) begin : mon
        t_dist_word       due;
        t_dist_word       w;
        logic [IDX_W-1:0] c_idx;
        int               n_eff;
        longint           ax, bx, ay, by, dx, dy;
        longint unsigned  sq;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                words_seen++;
                if (dist_due_q.size() == 0) begin
                    $display("%0t: unexpected word dist=%0d col=%0d last=%0b err=%0b",
                             $time, o_m_tdata[DIST_W-1:0], o_m_tdata[DIST_W +: IDX_W],
                             o_m_tlast, o_m_tuser);
                    fail_cnt++;
                end else begin
                    due = dist_due_q.pop_front();
                    if (o_m_tdata[DIST_W-1:0] !== due.dval ||
                        o_m_tdata[DIST_W +: IDX_W] !== due.col ||
                        o_m_tlast !== due.last || o_m_tuser !== due.err) begin
                        $display("%0t: mismatch expected dist=%0d col=%0d last=%0b err=%0b",
                                 $time, due.dval, due.col, due.last, due.err);
                        $display("%0t:          actual   dist=%0d col=%0d last=%0b err=%0b",
                                 $time, o_m_tdata[DIST_W-1:0], o_m_tdata[DIST_W +: IDX_W],
                                 o_m_tlast, o_m_tuser);
                        fail_cnt++;
                    end
                end
            end
            if (in_taken) begin
                cmds_taken++;
                c_idx = i_s_tdata[IDX_W-1:0];
                if (i_s_tuser == pdm_pkg::CMD_LOAD) begin
                    pt_x[c_idx] = i_s_tdata[IDX_W +: CRD_W];
                    pt_y[c_idx] = i_s_tdata[IDX_W+CRD_W +: CRD_W];
                    loads_done++;
                end else begin
                    rows_done++;
                    n_eff = (cities_cfg > N_SLOTS) ? N_SLOTS : int'(cities_cfg);
                    if (c_idx >= n_eff) begin
                        w.dval = '0;
                        w.col  = '0;
                        w.last = 1'b1;
                        w.err  = 1'b1;
                        dist_due_q.push_back(w);
                        err_words++;
                    end else begin
                        for (int j = 0; j < n_eff; j++) begin
                            ax = pt_x[c_idx];
                            bx = pt_x[j];
                            ay = pt_y[c_idx];
                            by = pt_y[j];
                            dx = (ax >= bx) ? ax - bx : bx - ax;
                            dy = (ay >= by) ? ay - by : by - ay;
                            sq = dx * dx + dy * dy;
                            w.dval = floor_root(sq);
                            w.col  = j[IDX_W-1:0];
                            w.last = (j == n_eff - 1);
                            w.err  = 1'b0;
                            dist_due_q.push_back(w);
                        end
                    end
                end
            end
        end
    end

    // input side: hold the word until taken, then maybe offer the next one
    always @(negedge i_clk) begin : feed
        t_point_cmd nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_taken) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pend_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= nxt.cmd;
                i_s_tdata  <= IN_DW'({nxt.y, nxt.x, nxt.idx});
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= i_rst_n && !(hold_go && !hold_done) &&
                      ($urandom_range(99) >= stall_pct);
    end

    // long output hold-off, counted here once the sequence asks for it
    initial begin
        wait (hold_go);
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_done = 1'b1;
    end

    task automatic push_cmd(input logic cmd, input int idx,
                            input logic [CRD_W-1:0] x, input logic [CRD_W-1:0] y);
        t_point_cmd it;
        it.cmd = cmd;
        it.idx = idx[IDX_W-1:0];
        it.x   = x;
        it.y   = y;
        pend_q.push_back(it);
        cmds_pushed++;
    endtask

    task automatic drain();
        while (cmds_taken != cmds_pushed || dist_due_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_city_count(input logic [CNT_W-1:0] v);
        drain();
        // a trailing load leaves no word behind, give it time to retire
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        cities_cfg   = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [CRD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: begin
                return 24'h7FFFFF;
            end
            1: begin
                return 24'h800000;
            end
            2: begin
                return 24'h000000;
            end
            3: begin
                return 24'hFFFFFF;
            end
            default: begin
                return CRD_W'($urandom());
            end
        endcase
    endfunction

    // every slot is loaded before this is used, so no row reads an unloaded point
    task automatic add_random(input int count, input int n_eff);
        int idx;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 25) begin
                push_cmd(pdm_pkg::CMD_LOAD, $urandom_range(N_SLOTS - 1), rand_coord(),
                         rand_coord());
            end else begin
                if (n_eff < N_SLOTS && $urandom_range(99) < 15) begin
                    idx = $urandom_range(N_SLOTS - 1, n_eff);
                end else begin
                    idx = $urandom_range(n_eff - 1, 0);
                end
                push_cmd(pdm_pkg::CMD_ROW, idx, '0, '0);
            end
        end
    endtask

    initial begin : seq
        int n;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // four cities, corner coordinates
        set_city_count(7'd4);
        push_cmd(pdm_pkg::CMD_LOAD, 0, 24'h7FFFFF, 24'h7FFFFF);
        push_cmd(pdm_pkg::CMD_LOAD, 1, 24'h800000, 24'h800000);
        push_cmd(pdm_pkg::CMD_LOAD, 2, 24'h000000, 24'h000000);
        push_cmd(pdm_pkg::CMD_LOAD, 3, 24'hFFFFFF, 24'h7FFFFF);
        push_cmd(pdm_pkg::CMD_LOAD, 63, 24'h800000, 24'h000001);
        for (int r = 0; r < 4; r++) begin
            push_cmd(pdm_pkg::CMD_ROW, r, '0, '0);
        end
        push_cmd(pdm_pkg::CMD_ROW, 4, '0, '0);
        push_cmd(pdm_pkg::CMD_ROW, 63, '0, '0);

        // zero cities: every row is an index error
        set_city_count(7'd0);
        push_cmd(pdm_pkg::CMD_ROW, 0, '0, '0);
        push_cmd(pdm_pkg::CMD_ROW, 63, '0, '0);

        // single city
        set_city_count(7'd1);
        push_cmd(pdm_pkg::CMD_ROW, 0, '0, '0);
        push_cmd(pdm_pkg::CMD_ROW, 1, '0, '0);

        // oversized count saturates; fill every slot first
        set_city_count(7'd127);
        for (int s = 0; s < N_SLOTS; s++) begin
            push_cmd(pdm_pkg::CMD_LOAD, s, rand_coord(), rand_coord());
        end
        add_random(5, N_SLOTS);

        set_city_count(7'd64);
        send_idle_pct = 51;
        add_random(10, N_SLOTS);

        n = $urandom_range(16, 2);
        set_city_count(n[CNT_W-1:0]);
        send_idle_pct = 0;
        stall_pct     = 51;
        add_random(15, n);

        n = $urandom_range(8, 1);
        set_city_count(n[CNT_W-1:0]);
        send_idle_pct = 27;
        stall_pct     = 27;
        add_random(15, n);

        // output held off while full rows keep coming in
        set_city_count(7'd65);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b1;
        for (int r = 0; r < 10; r++) begin
            push_cmd(pdm_pkg::CMD_ROW, $urandom_range(N_SLOTS - 1), '0, '0);
        end

        // sender pauses halfway until the output side is empty
        set_city_count(7'd3);
        send_idle_pct = 27;
        stall_pct     = 27;
        add_random(8, 3);
        drain();
        add_random(8, 3);

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d commands taken: %0d loads, %0d rows, %0d words checked (%0d index errors)",
                 cmds_taken, loads_done, rows_done, words_seen, err_words);
        $display("%0d city count writes incl. zero, one, 64 and saturating; output hold-off and "
                 , cfg_writes, "sender pause exercised");
        if (fail_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== pairwise_distance_matrix_core.f =====
src/pdm_pkg.sv
src/pdm_row_seq.sv
src/pdm_dist_calc.sv
src/pdm_sqrt_pipe.sv
src/pairwise_distance_matrix_core.sv
sim/tb.sv
